// ===== rtl/sae_pkg.sv =====
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types, constants and helpers of the sprite attribute expander.
// ----------------------------------------------------------------------------
`default_nettype none

package sae_pkg;

  // Field positions and limits of a sprite-list entry
  localparam int unsigned CodeW        = 13;
  localparam int unsigned BankW        = 4;
  localparam int unsigned SpanW        = 3;
  localparam int unsigned CoordW       = 10;
  localparam int unsigned CalcW        = 11;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCountW  = $clog2(QueueDepth + 1);

  localparam logic signed [CalcW-1:0] XWrap     = 11'sd320;
  localparam logic signed [CalcW-1:0] YWrap     = 11'sd256;
  localparam logic signed [CalcW-1:0] WrapSpan  = 11'sd512;
  localparam logic signed [CalcW-1:0] XOrigin   = 11'sd304;
  localparam logic signed [CalcW-1:0] YOrigin   = 11'sd240;
  localparam logic signed [CalcW-1:0] XRightLim = 11'sd320;

  // Decoded sprite, as handed from the front end to the back end
  typedef struct packed {
    logic [CodeW-1:0]         base;
    logic [SpanW-1:0]         span;   // tiles in column minus one
    logic [BankW-1:0]         bank;
    logic                     fx;
    logic                     fy;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
  } sae_desc_t;

  typedef struct packed {
    logic      push;
    sae_desc_t desc;
  } sae_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sae_qstat_t;

  // Column height code to (tile count - 1)
  function automatic logic [SpanW-1:0] span_of(input logic [1:0] height);
    logic [SpanW-1:0] s;
    case (height)
      2'd0:    s = 3'd0;
      2'd1:    s = 3'd1;
      2'd2:    s = 3'd3;
      2'd3:    s = 3'd7;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sae_if.sv =====
// ----------------------------------------------------------------------------
// sae_if
// Valid/ready channel interfaces for sprite entries and tile-draw commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface sae_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] position_word;
  logic [15:0] code_word;
  logic [15:0] x_word;
  logic        odd_frame;

  modport source (output valid, position_word, code_word, x_word, odd_frame,
                  input ready);
  modport sink   (input valid, position_word, code_word, x_word, odd_frame,
                  output ready);
endinterface

interface sae_out_if;
  logic              valid;
  logic              ready;
  logic [12:0]       tile_code;
  logic [3:0]        palette_bank;
  logic              flip_x;
  logic              flip_y;
  logic signed [9:0] screen_x;
  logic signed [9:0] screen_y;
  logic              last;

  modport source (output valid, tile_code, palette_bank, flip_x, flip_y,
                  screen_x, screen_y, last, input ready);
  modport sink   (input valid, tile_code, palette_bank, flip_x, flip_y,
                  screen_x, screen_y, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/sae_front.sv =====
// ----------------------------------------------------------------------------
// sae_front
// Accept sprite entries, drop hidden ones and decode the rest for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_front
  import sae_pkg::*;
(
  sae_in_if.sink     sprite_in,
  input  sae_qstat_t qstat,
  output sae_push_t  qpush
);

  logic [CodeW-1:0]        code;
  logic signed [CalcW-1:0] x_raw;
  logic signed [CalcW-1:0] y_raw;
  logic signed [CalcW-1:0] x_adj;
  logic signed [CalcW-1:0] y_adj;
  logic signed [CalcW-1:0] sx_full;
  logic signed [CalcW-1:0] sy_full;
  logic [SpanW-1:0]        span;
  logic                    hidden;

  assign sprite_in.ready = !qstat.full;

  always_comb begin
    code    = sprite_in.code_word[CodeW-1:0];
    x_raw   = $signed({2'b00, sprite_in.x_word[8:0]});
    y_raw   = $signed({2'b00, sprite_in.position_word[8:0]});
    x_adj   = (x_raw >= XWrap) ? x_raw - WrapSpan : x_raw;
    y_adj   = (y_raw >= YWrap) ? y_raw - WrapSpan : y_raw;
    sx_full = XOrigin - x_adj;
    sy_full = YOrigin - y_adj;
    span    = span_of(sprite_in.position_word[10:9]);
    // unused entry, flashing on odd frame, or past the right edge
    hidden  = (code == '0)
           || (sprite_in.position_word[12] && sprite_in.odd_frame)
           || (sx_full > XRightLim);

    qpush.push      = sprite_in.valid && !qstat.full && !hidden;
    qpush.desc.base = code & ~{{(CodeW-SpanW){1'b0}}, span};
    qpush.desc.span = span;
    qpush.desc.bank = sprite_in.x_word[12:9];
    qpush.desc.fx   = sprite_in.position_word[13];
    qpush.desc.fy   = sprite_in.position_word[14];
    qpush.desc.sx   = sx_full[CoordW-1:0];
    qpush.desc.sy   = sy_full[CoordW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/sae_queue.sv =====
// ----------------------------------------------------------------------------
// sae_queue
// Short FIFO of decoded sprites between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_queue
  import sae_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sae_push_t  qpush,
  input  logic       pop,
  output sae_qstat_t qstat,
  output sae_desc_t  head
);

  sae_desc_t              entries [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueueCountW-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign qstat.full  = (count == QueueCountW'(QueueDepth));
  assign qstat.empty = (count == '0);
  assign head        = entries[rd_ptr];
  assign do_push     = qpush.push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= qpush.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sae_back.sv =====
// ----------------------------------------------------------------------------
// sae_back
// Walk a decoded sprite down its column, one tile per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_back
  import sae_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sae_qstat_t qstat,
  input  sae_desc_t  head,
  output logic       pop,
  sae_out_if.source  tile_out
);

  sae_desc_t               cur;
  logic [SpanW-1:0]        step;
  logic                    busy;
  logic                    advance;
  logic [SpanW-1:0]        offset;
  logic signed [CoordW-1:0] ty;

  assign advance = !tile_out.valid || tile_out.ready;
  assign pop     = !busy && !qstat.empty;

  always_comb begin
    offset = cur.fy ? step : (cur.span & ~step);
    ty     = cur.sy - $signed({{(CoordW-SpanW-4){1'b0}}, step, 4'b0000});
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (busy && advance) begin
      tile_out.tile_code    <= cur.base | {{(CodeW-SpanW){1'b0}}, offset};
      tile_out.palette_bank <= cur.bank;
      tile_out.flip_x       <= cur.fx;
      tile_out.flip_y       <= cur.fy;
      tile_out.screen_x     <= cur.sx;
      tile_out.screen_y     <= ty;
      tile_out.last         <= (step == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      step           <= '0;
      tile_out.valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        step <= head.span;
      end else if (busy && advance) begin
        if (step == '0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 1'b1;
        end
      end
      if (advance) begin
        tile_out.valid <= busy;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sprite_attribute_expander_core.sv =====
// Order: a visible sprite's entry is written into the queue, loaded into the
// back end, and its tile commands are registered at the output one per cycle
// while the output is not stalled. A sprite of 1, 2, 4 or 8 tiles holds the command
// stepper until its last tile is issued; a hidden entry is dropped at acceptance.
// Reset: synchronous, active high; empties the queue and the output stage.
// ----------------------------------------------------------------------------
// sprite_attribute_expander_core
// Expand sprite-list entries into per-tile draw commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_attribute_expander_core
  import sae_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sae_in_if.sink    sprite_in,
  sae_out_if.source tile_out
);

  // Front end: take an entry whenever the queue has room, drop unused,
  // flashing-on-odd-frame and off-right entries there and then, and decode
  // position, span and base code for the survivors.
  sae_push_t  qpush;
  sae_qstat_t qstat;
  sae_desc_t  head;
  logic       pop;

  sae_front u_front (
    .sprite_in (sprite_in),
    .qstat     (qstat),
    .qpush     (qpush)
  );

  // Two-entry queue: lets the front keep taking entries while the back
  // is still working down a tall column or stalled by the consumer.
  sae_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  // Back end: load one sprite, then step from the top tile of the column
  // to the bottom, one registered command per cycle; hold on back-pressure.
  sae_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .head     (head),
    .pop      (pop),
    .tile_out (tile_out)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_sprite_attribute_expander_core.sv =====
// ----------------------------------------------------------------------------
// tb_sprite_attribute_expander_core
// Self-checking bench for the sprite attribute expander. It walks a table of
// directed sprite entries, then a stream of random ones. Random entries and some
// directed ones are run through an independent model of the column expansion;
// every tile-draw command is checked in order against what is expected. Both
// channels idle at random, and the output side is held off for a long stretch.
// ----------------------------------------------------------------------------

module tb_sprite_attribute_expander_core;
  import sae_pkg::*;

  // Screen geometry of the sprite list
  localparam int XWrapAt      = 320;
  localparam int YWrapAt      = 256;
  localparam int WrapDistance = 512;
  localparam int XScreenEdge  = 304;
  localparam int YScreenEdge  = 240;
  localparam int XHiddenAbove = 320;
  localparam int TilePitch    = 16;

  // Run control
  localparam int NumRows       = 19;
  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 150;
  localparam int DrainCycles   = 16;
  localparam int RandomPerLeg  = 144;

  typedef struct packed {
    logic [CodeW-1:0]         tile_code;
    logic [BankW-1:0]         palette_bank;
    logic                     flip_x;
    logic                     flip_y;
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic                     last;
  } tile_cmd_t;

  // How the expected commands of a table row are obtained
  typedef enum logic [1:0] {
    ROW_PREDICT,   // expand through the model
    ROW_HIDDEN,    // entry draws nothing
    ROW_ONE_TILE   // single command, typed into the row
  } row_kind_t;

  typedef struct {
    logic [15:0] pos;
    logic [15:0] code_w;
    logic [15:0] xw;
    logic        odd;
    row_kind_t   kind;
    tile_cmd_t   cmd;
  } sprite_row_t;

  localparam tile_cmd_t NoTile = '0;

  // Directed entries: corners of the screen, every column height with and
  // without flips, the three hidden cases and the cleared-base case.
  sprite_row_t directed_rows [NumRows] = '{
    // top-left raw origin, single tile
    '{16'h0000, 16'h0001, 16'h0000, 1'b0, ROW_ONE_TILE,
      '{13'h0001, 4'd0, 1'b0, 1'b0, 10'sd304, 10'sd240, 1'b1}},
    // raw y 511 and raw x 319: both fold or sit at the edge
    '{16'h01ff, 16'h1fff, 16'h013f, 1'b0, ROW_ONE_TILE,
      '{13'h1fff, 4'd0, 1'b0, 1'b0, -10'sd15, 10'sd241, 1'b1}},
    // ignored bits all set, both flips, right-most visible x, top bank
    '{16'he8ff, 16'hffff, 16'hfff0, 1'b0, ROW_ONE_TILE,
      '{13'h1fff, 4'd15, 1'b1, 1'b1, 10'sd320, -10'sd15, 1'b1}},
    // flashing sprite on an even frame stays visible; y folds to 496
    '{16'h1100, 16'h0800, 16'h0100, 1'b0, ROW_ONE_TILE,
      '{13'h0800, 4'd0, 1'b0, 1'b0, 10'sd48, 10'sd496, 1'b1}},
    // unused entry: code zero with high bits set
    '{16'h0000, 16'he000, 16'h0000, 1'b0, ROW_HIDDEN, NoTile},
    // flashing sprite on an odd frame
    '{16'h1000, 16'h0001, 16'h0000, 1'b1, ROW_HIDDEN, NoTile},
    // raw x 320 folds to screen x 496, off to the right
    '{16'h0000, 16'h0001, 16'h0140, 1'b0, ROW_HIDDEN, NoTile},
    // screen x 321, one past the edge
    '{16'h0000, 16'h0001, 16'h01ef, 1'b0, ROW_HIDDEN, NoTile},
    // odd frame without flash is drawn
    '{16'h0000, 16'h0001, 16'h0001, 1'b1, ROW_ONE_TILE,
      '{13'h0001, 4'd0, 1'b0, 1'b0, 10'sd303, 10'sd240, 1'b1}},
    '{16'h0200, 16'h0003, 16'h0020, 1'b0, ROW_PREDICT, NoTile},
    '{16'h4200, 16'h0003, 16'h0020, 1'b0, ROW_PREDICT, NoTile},
    '{16'h0400, 16'h0005, 16'h0040, 1'b0, ROW_PREDICT, NoTile},
    '{16'h4400, 16'h0abc, 16'h1e40, 1'b0, ROW_PREDICT, NoTile},
    // nonzero code whose base clears to zero is still drawn
    '{16'h0600, 16'h0007, 16'h0000, 1'b0, ROW_PREDICT, NoTile},
    // tallest column with y flipped, reaching above the top of the screen
    '{16'h46ff, 16'h1fff, 16'h0000, 1'b0, ROW_PREDICT, NoTile},
    '{16'h2700, 16'h1ff8, 16'h01f0, 1'b1, ROW_PREDICT, NoTile},
    // all bits set on an odd frame: hidden by flash
    '{16'h7fff, 16'hffff, 16'hffff, 1'b1, ROW_HIDDEN, NoTile},
    '{16'h7fff, 16'hffff, 16'hffff, 1'b0, ROW_PREDICT, NoTile},
    '{16'h8600, 16'h0100, 16'h0000, 1'b0, ROW_PREDICT, NoTile}
  };

  logic clk = 1'b0;
  logic rst;

  sae_in_if  sprite_in ();
  sae_out_if tile_out ();

  sprite_attribute_expander_core dut (
    .clk       (clk),
    .rst       (rst),
    .sprite_in (sprite_in),
    .tile_out  (tile_out)
  );

  tile_cmd_t pending_tiles [$];   // commands still owed by the block, oldest first
  row_kind_t row_kind  = ROW_PREDICT;
  tile_cmd_t typed_cmd = NoTile;
  int        errors        = 0;
  int        quiet_cycles  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_req      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expand one sprite entry into its column of tile commands and queue them.
  // The screen position is worked out in plain integers, then cut to the
  // port width, so that wrap-around on the output is seen as the block sees it.
  function automatic void expand_sprite(input logic [15:0] pos,
                                        input logic [15:0] code_w,
                                        input logic [15:0] xw,
                                        input logic        odd);
    int        x;
    int        y;
    int        ty;
    int        n;
    int        m;
    int        base;
    int        tile;
    tile_cmd_t cmd;
    if (code_w[12:0] == '0) return;
    if (pos[12] && odd) return;
    n = (1 << pos[10:9]) - 1;
    x = int'(xw[8:0]);
    y = int'(pos[8:0]);
    if (x >= XWrapAt) x -= WrapDistance;
    if (y >= YWrapAt) y -= WrapDistance;
    x = XScreenEdge - x;
    y = YScreenEdge - y;
    if (x > XHiddenAbove) return;
    base = int'(code_w[12:0]) & ~n;
    // walk down from the top tile; flip y reverses the code order only
    for (m = n; m >= 0; m--) begin
      tile = pos[14] ? base + m : base + n - m;
      ty   = y - TilePitch * m;
      cmd.tile_code    = tile[CodeW-1:0];
      cmd.palette_bank = xw[12:9];
      cmd.flip_x       = pos[13];
      cmd.flip_y       = pos[14];
      cmd.screen_x     = x[CoordW-1:0];
      cmd.screen_y     = ty[CoordW-1:0];
      cmd.last         = (m == 0);
      pending_tiles.push_back(cmd);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Present one entry at the falling edge and hold it until the block takes
  // it. Idle cycles go in front, so a gap never splits a transaction.
  task automatic send_entry(input logic [15:0] pos, input logic [15:0] code_w,
                            input logic [15:0] xw, input logic odd,
                            input row_kind_t kind, input tile_cmd_t cmd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sprite_in.valid <= 1'b0;
      @(negedge clk);
    end
    row_kind                <= kind;
    typed_cmd               <= cmd;
    sprite_in.position_word <= pos;
    sprite_in.code_word     <= code_w;
    sprite_in.x_word        <= xw;
    sprite_in.odd_frame     <= odd;
    sprite_in.valid         <= 1'b1;
    do @(posedge clk); while (!sprite_in.ready);
  endtask

  // Random entries: mostly visible sprites with random content, plus a share
  // of unused, flashing and off-screen ones.
  task automatic send_random_sprites(input int count);
    int          k;
    logic [15:0] pos;
    logic [15:0] code_w;
    logic [15:0] xw;
    logic        odd;
    for (k = 0; k < count; k++) begin
      pos    = 16'($urandom);
      code_w = 16'($urandom);
      xw     = 16'($urandom);
      odd    = 1'($urandom);
      if ($urandom_range(3) != 0) pos[12] = 1'b0;
      if ($urandom_range(19) == 0) code_w[12:0] = '0;
      else if ($urandom_range(9) == 0) code_w[12:0] = 13'($urandom_range(7));
      case ($urandom_range(9))
        0:       ;   // keep the raw x, off-screen values included
        1, 2:    xw[8:0] = 9'($urandom_range(511, 496));
        default: xw[8:0] = 9'($urandom_range(319, 0));
      endcase
      send_entry(pos, code_w, xw, odd, ROW_PREDICT, NoTile);
    end
  endtask

  // Output side: hold ready low in reset, then drop it at random, or for a
  // whole hold-off stretch when one is requested.
  always @(negedge clk) begin
    int hold_left;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      tile_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      tile_out.ready <= 1'b0;
      hold_left--;
    end else begin
      tile_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Scoreboard: queue predictions for each taken entry, then retire the
  // oldest prediction against each command the block hands over.
  always @(posedge clk) begin
    tile_cmd_t want;
    if (!rst) begin
      if (sprite_in.valid && sprite_in.ready) begin
        case (row_kind)
          ROW_PREDICT:  expand_sprite(sprite_in.position_word, sprite_in.code_word,
                                      sprite_in.x_word, sprite_in.odd_frame);
          ROW_ONE_TILE: pending_tiles.push_back(typed_cmd);
          default:      ;
        endcase
      end
      if (tile_out.valid && tile_out.ready) begin
        if (pending_tiles.size() == 0) begin
          $display("%0t: unexpected tile command, expected none, got code %0d",
                   $time, tile_out.tile_code);
          errors++;
        end else begin
          want = pending_tiles.pop_front();
          check_field("tile_code", want.tile_code, tile_out.tile_code);
          check_field("palette_bank", want.palette_bank, tile_out.palette_bank);
          check_field("flip_x", want.flip_x, tile_out.flip_x);
          check_field("flip_y", want.flip_y, tile_out.flip_y);
          check_field("screen_x", want.screen_x, tile_out.screen_x);
          check_field("screen_y", want.screen_y, tile_out.screen_y);
          check_field("last", want.last, tile_out.last);
        end
      end
      // Watchdog: any transaction on either side counts as progress
      if ((sprite_in.valid && sprite_in.ready) || (tile_out.valid && tile_out.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    rst                     = 1'b1;
    sprite_in.valid         = 1'b0;
    sprite_in.position_word = '0;
    sprite_in.code_word     = '0;
    sprite_in.x_word        = '0;
    sprite_in.odd_frame     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First leg: sender idles lightly, receiver heavily
    send_idle_pct = 10;
    recv_idle_pct = 57;
    for (i = 0; i < NumRows; i++)
      send_entry(directed_rows[i].pos, directed_rows[i].code_w, directed_rows[i].xw,
                 directed_rows[i].odd, directed_rows[i].kind, directed_rows[i].cmd);

    // Pause the sender until the block has handed over everything owed
    @(negedge clk);
    sprite_in.valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);

    send_random_sprites(RandomPerLeg);

    // Second leg: the other way round
    send_idle_pct = 57;
    recv_idle_pct = 10;
    send_random_sprites(RandomPerLeg);

    // Third leg: no idling, but hold the output off for a long stretch while
    // entries keep coming, so that the block backs up into its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = HoldOffCycles;
    send_random_sprites(RandomPerLeg);

    @(negedge clk);
    sprite_in.valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    // Leave room for any stray command after the last expected one
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
